// ===== rtl/bfp_pkg.sv =====
// Package for the bit FIFO with peek: sizes, operation and status codes, word types.
`timescale 1ns / 1ps

package bfp_pkg;

    // Number of slots; the FIFO holds at most DEPTH-1 bits
    localparam int DEPTH = 256;
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int OFS_W = 8;
    localparam int CNT_OUT_W = 8;
    // Width that holds both an offset and a count for comparison
    localparam int CMP_W = (PTR_W > OFS_W) ? PTR_W : OFS_W;

    // Operation codes
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic             push_bit;
        logic [OFS_W-1:0] peek_offset;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           status;
        logic                 read_bit;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_empty;
        logic                 is_full;
    } t_out_word;

endpackage

// ===== rtl/bit_fifo_with_peek_unit.sv =====
// Top level of the bit FIFO with peek: bit store, pointers, count and result pipeline.
`timescale 1ns / 1ps

// One-bit-wide circular FIFO with DEPTH slots that holds up to DEPTH-1 bits. Each input word
// is a push, a pop or a peek at an offset from the oldest bit, and yields exactly one result
// word with status, the bit read, the count after the operation and the empty/full flags.
// The bit store is a synchronous memory with a registered read: an operation is
// decided and the pointers move in the cycle it is accepted, the addressed slot is read at
// that edge, and the decided result waits in the middle stage until the output register is
// free or taken, then moves there. The unit takes one word per cycle as long as results
// are taken; the memory port serves one operation per cycle.
// Slots need no clearing after reset, as the read bit is forced to zero unless the read was allowed.
module bit_fifo_with_peek_unit
    import bfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // Bit store
    logic r_mem [DEPTH];

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_count, n_count;

    // Middle stage: decided result waiting for the memory read data
    logic                 r_s1_valid;
    logic [1:0]           r_s1_status;
    logic                 r_s1_read_ok;
    logic [CNT_OUT_W-1:0] r_s1_count;
    logic                 r_s1_empty;
    logic                 r_s1_full;
    logic                 r_rd_bit;

    logic      r_out_valid;
    t_out_word r_out_word;

    logic             accept;
    logic             s1_move;
    logic             is_empty_now;
    logic             is_full_now;
    logic [CMP_W-1:0] off_ext;
    logic             in_range;
    logic [PTR_W:0]   addr_sum;
    logic [PTR_W-1:0] rd_addr;
    logic             push_ok;
    logic             read_ok;
    logic             pop_ok;
    logic [1:0]       status;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc;

    // Handshake: middle stage drains into the output register when that is free or taken
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    // Decide the operation against the current count
    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == PTR_W'(DEPTH - 1));
    assign off_ext      = (i_in_word.mode == MODE_PEEK) ? CMP_W'(i_in_word.peek_offset) : '0;
    assign in_range     = off_ext < CMP_W'(r_count);

    // Wrap the read address; offset is below the count whenever it is used
    assign addr_sum = {1'b0, r_rd_ptr} + (PTR_W+1)'(off_ext);
    assign rd_addr  = (addr_sum >= (PTR_W+1)'(DEPTH)) ?
                      PTR_W'(addr_sum - (PTR_W+1)'(DEPTH)) : PTR_W'(addr_sum);

    assign rd_ptr_inc = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign wr_ptr_inc = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;

    always_comb begin
        status  = ST_OK;
        push_ok = 1'b0;
        read_ok = 1'b0;
        unique case (i_in_word.mode)
            MODE_PUSH: begin
                if (is_full_now) begin
                    status = ST_FULL;
                end else begin
                    push_ok = 1'b1;
                end
            end
            MODE_POP, MODE_PEEK: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    read_ok = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign pop_ok = read_ok && (i_in_word.mode == MODE_POP);

    // Advance pointers and count
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (accept && push_ok) begin
            n_wr_ptr = wr_ptr_inc;
            n_count  = r_count + 1'b1;
        end
        if (accept && pop_ok) begin
            n_rd_ptr = rd_ptr_inc;
            n_count  = r_count - 1'b1;
        end
    end

    // Write the pushed bit, read the addressed slot
    always_ff @(posedge i_clk) begin
        if (accept && push_ok) begin
            r_mem[r_wr_ptr] <= i_in_word.push_bit;
        end
        if (accept) begin
            r_rd_bit <= r_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the decided result, then merge the read bit into the output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status  <= status;
            r_s1_read_ok <= read_ok;
            r_s1_count   <= CNT_OUT_W'(n_count);
            r_s1_empty   <= (n_count == '0);
            r_s1_full    <= (n_count == PTR_W'(DEPTH - 1));
        end
        if (s1_move) begin
            r_out_word.status   <= r_s1_status;
            r_out_word.read_bit <= r_s1_read_ok & r_rd_bit;
            r_out_word.count    <= r_s1_count;
            r_out_word.is_empty <= r_s1_empty;
            r_out_word.is_full  <= r_s1_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
